// ===== src/rpn_pkg.sv =====
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;

  // index of one cell, and a count that can also hold the full depth
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W = (DATA_WIDTH > CNT_W) ? DATA_WIDTH : CNT_W;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [STACK_DEPTH-1:0][DATA_WIDTH-1:0] word_vec_t;

  typedef enum logic [3:0] {
    CMD_PUSH   = 4'd0,
    CMD_DROP   = 4'd1,
    CMD_DROP2  = 4'd2,
    CMD_DROPN  = 4'd3,
    CMD_DUP    = 4'd4,
    CMD_DUP2   = 4'd5,
    CMD_DUPN   = 4'd6,
    CMD_OVER   = 4'd7,
    CMD_SWAP   = 4'd8,
    CMD_CLEAR  = 4'd9,
    CMD_DEPTH  = 4'd10,
    CMD_ROLL   = 4'd11,
    CMD_ROLLN  = 4'd12,
    CMD_ROLLD  = 4'd13,
    CMD_ROLLDN = 4'd14,
    CMD_PICK   = 4'd15
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] push_value;
  } rpn_req_t;

  typedef struct packed {
    logic               ok;
    logic [4:0]         fill_level;
    logic signed [31:0] bottom_value;
  } rpn_rsp_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_SWAP,
    CELL_LOAD0
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] lim;
    word_t            ins;
  } cell_ctl_t;

endpackage

// ===== src/rpn_cell.sv =====
module rpn_cell
  import rpn_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] idx,
  input  word_t            below,
  input  word_t            above,
  output word_t            word
);

  word_t word_next;

  always_comb begin
    word_next = word;
    case (ctl.op)
      CELL_HOLD:       word_next = word;
      CELL_SHIFT_UP:   word_next = below;
      CELL_SHIFT_DOWN: begin
        // cells under the limit take from above, the limit cell takes the insert word
        if (idx < ctl.lim) begin
          word_next = above;
        end else if (idx == ctl.lim) begin
          word_next = ctl.ins;
        end
      end
      CELL_SWAP: begin
        if (idx == IDX_W'(0)) begin
          word_next = above;
        end else if (idx == IDX_W'(1)) begin
          word_next = below;
        end
      end
      CELL_LOAD0: begin
        if (idx == IDX_W'(0)) begin
          word_next = ctl.ins;
        end
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== src/rpn_seq.sv =====
module rpn_seq
  import rpn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  rpn_req_t  req,
  input  word_vec_t words,
  output cell_ctl_t ctl,
  output logic      busy,
  output logic      done,
  output rpn_rsp_t  rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOOP
  } state_t;

  typedef enum logic [2:0] {
    LOOP_DROP,
    LOOP_DUP2,
    LOOP_DUPN,
    LOOP_ROLL_UP,
    LOOP_ROLL_DOWN
  } loop_op_t;

  localparam logic [CNT_W:0] DEPTH_X  = (CNT_W + 1)'(STACK_DEPTH);
  localparam logic [CNT_W:0] DEPTH_P1 = (CNT_W + 1)'(STACK_DEPTH + 1);

  state_t           state;
  cmd_t             cmd_r;
  word_t            pv_r;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] iter;
  logic [IDX_W-1:0] cidx;
  loop_op_t         loop_op;
  logic             ok_r;

  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] iter_c;
  logic [IDX_W-1:0] cidx_c;
  loop_op_t         loop_op_c;
  logic             ok_c;

  word_t            w0;
  logic [IDX_W-1:0] c;
  logic [IDX_W-1:0] lim_cur;
  logic             cnt_ok;
  logic [IDX_W-1:0] rd_idx;
  word_t            rd_word;

  assign w0      = words[0];
  assign c       = w0[IDX_W-1:0];
  assign lim_cur = IDX_W'(count - CNT_W'(1));
  // count word must be non-negative and below the entry count
  assign cnt_ok  = (count != '0) && !w0[DATA_WIDTH-1] && (CMP_W'(w0) < CMP_W'(count));

  always_comb begin
    rd_idx = '0;
    if (state == ST_EXEC) begin
      case (cmd_r)
        CMD_DUP2, CMD_OVER: rd_idx = IDX_W'(1);
        CMD_ROLL:           rd_idx = lim_cur;
        CMD_PICK:           rd_idx = c;
        default:            rd_idx = '0;
      endcase
    end else begin
      case (loop_op)
        LOOP_DUP2:    rd_idx = IDX_W'(1);
        LOOP_DUPN:    rd_idx = cidx;
        LOOP_ROLL_UP: rd_idx = lim_cur;
        default:      rd_idx = '0;
      endcase
    end
  end

  assign rd_word = words[rd_idx];

  always_comb begin
    ctl.op     = CELL_HOLD;
    ctl.lim    = lim_cur;
    ctl.ins    = w0;
    count_next = count;
    ok_c       = 1'b0;
    iter_c     = '0;
    cidx_c     = c - IDX_W'(1);
    loop_op_c  = LOOP_DROP;
    if (state == ST_EXEC) begin
      case (cmd_r)
        CMD_PUSH: begin
          if (count < CNT_W'(STACK_DEPTH)) begin
            ok_c       = 1'b1;
            ctl.op     = CELL_SHIFT_UP;
            ctl.ins    = pv_r;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_DROP: begin
          if (count >= CNT_W'(1)) begin
            ok_c       = 1'b1;
            ctl.op     = CELL_SHIFT_DOWN;
            count_next = count - CNT_W'(1);
          end
        end
        CMD_DROP2: begin
          if (count >= CNT_W'(2)) begin
            ok_c       = 1'b1;
            ctl.op     = CELL_SHIFT_DOWN;
            count_next = count - CNT_W'(1);
            iter_c     = IDX_W'(1);
            loop_op_c  = LOOP_DROP;
          end
        end
        CMD_DROPN: begin
          if (cnt_ok) begin
            ok_c       = 1'b1;
            ctl.op     = CELL_SHIFT_DOWN;
            count_next = count - CNT_W'(1);
            iter_c     = c;
            loop_op_c  = LOOP_DROP;
          end
        end
        CMD_DUP: begin
          if (count >= CNT_W'(1) && count < CNT_W'(STACK_DEPTH)) begin
            ok_c       = 1'b1;
            ctl.op     = CELL_SHIFT_UP;
            ctl.ins    = w0;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_DUP2: begin
          if (count >= CNT_W'(2) && ({1'b0, count} + (CNT_W + 1)'(2)) <= DEPTH_X) begin
            ok_c       = 1'b1;
            ctl.op     = CELL_SHIFT_UP;
            ctl.ins    = rd_word;
            count_next = count + CNT_W'(1);
            iter_c     = IDX_W'(1);
            loop_op_c  = LOOP_DUP2;
          end
        end
        CMD_DUPN: begin
          if (cnt_ok && ({1'b0, count} + (CNT_W + 1)'(c)) <= DEPTH_P1) begin
            ok_c       = 1'b1;
            ctl.op     = CELL_SHIFT_DOWN;
            count_next = count - CNT_W'(1);
            iter_c     = c;
            loop_op_c  = LOOP_DUPN;
          end
        end
        CMD_OVER: begin
          if (count >= CNT_W'(2) && count < CNT_W'(STACK_DEPTH)) begin
            ok_c       = 1'b1;
            ctl.op     = CELL_SHIFT_UP;
            ctl.ins    = rd_word;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_SWAP: begin
          if (count >= CNT_W'(2)) begin
            ok_c   = 1'b1;
            ctl.op = CELL_SWAP;
          end
        end
        CMD_CLEAR: begin
          ok_c       = 1'b1;
          count_next = '0;
        end
        CMD_DEPTH: begin
          if (count < CNT_W'(STACK_DEPTH)) begin
            ok_c       = 1'b1;
            ctl.op     = CELL_SHIFT_UP;
            ctl.ins    = DATA_WIDTH'(count);
            count_next = count + CNT_W'(1);
          end
        end
        CMD_ROLL: begin
          // top word re-enters at the bottom, count unchanged
          if (count >= CNT_W'(2)) begin
            ok_c    = 1'b1;
            ctl.op  = CELL_SHIFT_UP;
            ctl.ins = rd_word;
          end
        end
        CMD_ROLLN: begin
          if (cnt_ok) begin
            ok_c       = 1'b1;
            ctl.op     = CELL_SHIFT_DOWN;
            count_next = count - CNT_W'(1);
            iter_c     = c;
            loop_op_c  = LOOP_ROLL_UP;
          end
        end
        CMD_ROLLD: begin
          if (count >= CNT_W'(2)) begin
            ok_c    = 1'b1;
            ctl.op  = CELL_SHIFT_DOWN;
            ctl.ins = w0;
          end
        end
        CMD_ROLLDN: begin
          if (cnt_ok) begin
            ok_c       = 1'b1;
            ctl.op     = CELL_SHIFT_DOWN;
            count_next = count - CNT_W'(1);
            iter_c     = c;
            loop_op_c  = LOOP_ROLL_DOWN;
          end
        end
        CMD_PICK: begin
          if (cnt_ok && c != '0) begin
            ok_c    = 1'b1;
            ctl.op  = CELL_LOAD0;
            ctl.ins = rd_word;
          end
        end
        default: ok_c = 1'b0;
      endcase
    end else if (state == ST_LOOP) begin
      case (loop_op)
        LOOP_DROP: begin
          ctl.op     = CELL_SHIFT_DOWN;
          count_next = count - CNT_W'(1);
        end
        LOOP_DUP2, LOOP_DUPN: begin
          ctl.op     = CELL_SHIFT_UP;
          ctl.ins    = rd_word;
          count_next = count + CNT_W'(1);
        end
        LOOP_ROLL_UP: begin
          ctl.op  = CELL_SHIFT_UP;
          ctl.ins = rd_word;
        end
        LOOP_ROLL_DOWN: begin
          ctl.op  = CELL_SHIFT_DOWN;
          ctl.ins = w0;
        end
        default: ctl.op = CELL_HOLD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      iter  <= '0;
      done  <= 1'b0;
      ok_r  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_r <= req.cmd;
            pv_r  <= DATA_WIDTH'(req.push_value);
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          count <= count_next;
          ok_r  <= ok_c;
          if (ok_c && iter_c != '0) begin
            iter    <= iter_c;
            cidx    <= cidx_c;
            loop_op <= loop_op_c;
            state   <= ST_LOOP;
          end else begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_LOOP: begin
          count <= count_next;
          iter  <= iter - IDX_W'(1);
          if (iter == IDX_W'(1)) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    rsp.ok           = ok_r;
    rsp.fill_level   = 5'(count);
    rsp.bottom_value = (count != '0) ? 32'($signed(w0)) : '0;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("entry count above stack depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a command in progress");

  a_refuse_keeps: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.ok) |-> $stable(count))
    else $error("refused command changed the entry count");

endmodule

// ===== src/rpn_stack_engine_unit.sv =====
// rpn stack engine: bounded stack of signed words, one command per beat.
// command channel: a beat (req.cmd, req.push_value) is taken at the rising
// edge where start is high and busy is low; start is ignored while busy.
// result channel: done is high for exactly one cycle and rsp (ok,
// fill_level, bottom_value) is valid in that cycle only; the receiver
// cannot stall it, so it must take the result when done is high.
// sequence: after the accepting edge the command runs in the exec state,
// and done rises as the sequencer returns to idle. drop2 and dup2 add
// one more cell shift in a loop state; dropn, dupn, rolln and rolldn
// add c more, c being the count read from the bottom entry.
// busy is low again in the done cycle, so a new command can be
// taken then, but not before the last one is through.
// the loop comes from the cell chain: every entry sits in its own cell
// and words move one cell per cycle while busy, one neighbor shift per step.
// a refused command (ok low) leaves the stack untouched and returns to idle from the exec state.
// reset (rst, synchronous) empties the stack and drops any command in
// flight; entry words are not cleared, the entry count alone marks them.
module rpn_stack_engine_unit
  import rpn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  rpn_req_t req,
  output logic     busy,
  output logic     done,
  output rpn_rsp_t rsp
);

  cell_ctl_t ctl;
  word_vec_t words;
  word_vec_t below_w;
  word_vec_t above_w;

  rpn_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .words (words),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    // bottom cell is fed by the insert word, as is the top one from above
    if (g == 0) begin : g_first
      assign below_w[g] = ctl.ins;
    end else begin : g_rest
      assign below_w[g] = words[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_last
      assign above_w[g] = ctl.ins;
    end else begin : g_inner
      assign above_w[g] = words[g+1];
    end

    rpn_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (IDX_W'(g)),
      .below (below_w[g]),
      .above (above_w[g]),
      .word  (words[g])
    );
  end

endmodule
